[src/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VGA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define VGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/vga_irq_pkg.sv]
// ---------------------------------------------------------------------------
// vga_irq_pkg
// Shared types, codes and pixel decode for the video gate array.
// ---------------------------------------------------------------------------
package vga_irq_pkg;

  typedef enum logic [2:0] {
    REQ_BUS   = 3'd0,
    REQ_CHAR  = 3'd1,
    REQ_QUART = 3'd2,
    REQ_ACK   = 3'd3,
    REQ_VIDEO = 3'd4
  } req_t;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_FRAME = 2'd2;

  localparam logic [4:0] INK_BLACK  = 5'h14;
  localparam logic [4:0] PEN_BORDER = 5'd16;
  localparam logic [5:0] LINES_PER_IRQ = 6'd52;
  localparam logic [4:0] VSYNC_LINES   = 5'd26;

  // Status fields carried with every result word.
  typedef struct packed {
    logic       irq;
    logic       hs;
    logic       vs;
    logic       rom_lo;
    logic       rom_hi;
    logic [1:0] mode;
  } status_t;

  // Pen index of sample s of byte b in the given mode.
  function automatic logic [3:0] pen_for_sample(input logic [1:0] mode,
                                                input logic [7:0] b,
                                                input logic [2:0] s);
    logic [2:0] p;
    logic [3:0] r;
    begin
      r = 4'd0;
      case (mode)
        2'd0: begin
          p = {2'b00, s[2]};
          r = {b[3'd1 - p], b[3'd5 - p], b[3'd3 - p], b[3'd7 - p]};
        end
        2'd1: begin
          p = {1'b0, s[2:1]};
          r = {2'b00, b[3'd3 - p], b[3'd7 - p]};
        end
        2'd2: begin
          p = s;
          r = {3'b000, b[3'd7 - p]};
        end
        default: begin
          p = {2'b00, s[2]};
          r = {2'b00, b[3'd3 - p], b[3'd7 - p]};
        end
      endcase
      return r;
    end
  endfunction

endpackage

[src/vga_irq_ctrl.sv]
// ---------------------------------------------------------------------------
// vga_irq_ctrl
// Control state: bus registers, sync delay, line counter and interrupt.
// ---------------------------------------------------------------------------
module vga_irq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [2:0]           req_type,
  input  logic [7:0]           bus_data,
  input  logic                 hsync_in,
  input  logic                 vsync_in,
  output vga_irq_pkg::status_t st,
  output logic                 blanked,
  output logic                 ink_we,
  output logic [4:0]           ink_addr,
  output logic [4:0]           ink_data
);
  import vga_irq_pkg::*;

  logic [4:0] pen_r, pen_nxt;
  logic       rom_lo_r, rom_lo_nxt, rom_hi_r, rom_hi_nxt;
  logic [1:0] mode_w_r, mode_w_nxt, mode_a_r, mode_a_nxt;
  logic [5:0] lc_r, lc_nxt;
  logic       irq_r, irq_nxt, irq_new_r, irq_new_nxt;
  logic [1:0] recent_r, recent_nxt, due_r, due_nxt;
  logic       hl_r, hl_nxt, vl_r, vl_nxt;
  logic [1:0] fcd_r, fcd_nxt;
  logic [4:0] vlc_r, vlc_nxt;
  logic       vact_r, vact_nxt, vbl_r, vbl_nxt;
  logic [2:0] hcc_r, hcc_nxt;
  logic       hbl_r, hbl_nxt, hp_r, hp_nxt, vp_r, vp_nxt;
  logic [1:0] qp_r, qp_nxt;

  always_comb begin
    logic [5:0] lc_inc;
    logic [4:0] vlc_inc;
    logic       hr, hf, vr;
    pen_nxt = pen_r;       rom_lo_nxt = rom_lo_r;  rom_hi_nxt = rom_hi_r;
    mode_w_nxt = mode_w_r; mode_a_nxt = mode_a_r;  lc_nxt = lc_r;
    irq_nxt = irq_r;       irq_new_nxt = irq_new_r;
    recent_nxt = recent_r; due_nxt = due_r;        hl_nxt = hl_r;
    vl_nxt = vl_r;         fcd_nxt = fcd_r;        vlc_nxt = vlc_r;
    vact_nxt = vact_r;     vbl_nxt = vbl_r;        hcc_nxt = hcc_r;
    hbl_nxt = hbl_r;       hp_nxt = hp_r;          vp_nxt = vp_r;
    qp_nxt = qp_r;
    ink_we = 1'b0;
    ink_addr = pen_r;
    ink_data = bus_data[4:0];
    hr = hsync_in & ~hl_r;
    hf = hl_r & ~hsync_in;
    vr = vsync_in & ~vl_r;
    lc_inc = lc_r + 6'd1;
    vlc_inc = vlc_r + 5'd1;
    if (go) begin
      case (req_type)
        REQ_BUS: begin
          case (bus_data[7:6])
            2'b00: pen_nxt = bus_data[4] ? PEN_BORDER : {1'b0, bus_data[3:0]};
            2'b01: ink_we = (pen_r <= PEN_BORDER);
            2'b10: begin
              rom_hi_nxt = ~bus_data[3];
              rom_lo_nxt = ~bus_data[2];
              mode_w_nxt = bus_data[1:0];
              if (bus_data[4]) begin
                lc_nxt = 6'd0; irq_nxt = 1'b0;
                recent_nxt = ACT_NONE; due_nxt = ACT_NONE;
              end
            end
            default: ;
          endcase
        end
        REQ_CHAR: begin
          due_nxt = recent_r;
          recent_nxt = ACT_NONE;
          hl_nxt = hsync_in;
          vl_nxt = vsync_in;
          if (vr) begin
            fcd_nxt = 2'd2; vlc_nxt = 5'd0; vact_nxt = 1'b1; vbl_nxt = 1'b1;
          end
          if (hr) begin
            hcc_nxt = 3'd0; hbl_nxt = 1'b1;
          end else if (hcc_r < 3'd6) begin
            hcc_nxt = hcc_r + 3'd1;
            if (hcc_nxt == 3'd2) hp_nxt = 1'b1;
            else if (hcc_nxt == 3'd6) hp_nxt = 1'b0;
          end
          if (hf) begin
            hp_nxt = 1'b0; hbl_nxt = 1'b0;
            if (vact_nxt) begin
              vlc_nxt = (vr ? 5'd1 : vlc_inc);
              if (vlc_nxt == 5'd2) vp_nxt = 1'b1;
              else if (vlc_nxt == 5'd6) vp_nxt = 1'b0;
              else if (vlc_nxt == VSYNC_LINES) begin
                vbl_nxt = 1'b0; vact_nxt = 1'b0;
              end
            end
            mode_a_nxt = mode_w_r;
            recent_nxt = ACT_STEP;
            if (fcd_nxt != 2'd0) begin
              fcd_nxt = fcd_nxt - 2'd1;
              if (fcd_nxt == 2'd0) recent_nxt = ACT_FRAME;
            end
          end
        end
        REQ_QUART: begin
          qp_nxt = qp_r + 2'd1;
          irq_new_nxt = 1'b0;
          if (qp_nxt == 2'd1 && due_r != ACT_NONE) begin
            due_nxt = ACT_NONE;
            if (due_r == ACT_FRAME) begin
              if (lc_r[5]) begin irq_nxt = 1'b1; irq_new_nxt = 1'b1; end
              lc_nxt = 6'd0;
            end else if (due_r == ACT_STEP) begin
              lc_nxt = lc_inc;
              if (lc_inc == LINES_PER_IRQ) begin
                lc_nxt = 6'd0; irq_nxt = 1'b1; irq_new_nxt = 1'b1;
              end
            end
          end
        end
        REQ_ACK: begin
          if (!irq_new_r) irq_nxt = 1'b0;
          lc_nxt = {1'b0, lc_r[4:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0; rom_lo_r <= 1'b1; rom_hi_r <= 1'b1; mode_w_r <= '0;
      mode_a_r <= '0; lc_r <= '0; irq_r <= 1'b0; irq_new_r <= 1'b0;
      recent_r <= ACT_NONE; due_r <= ACT_NONE; hl_r <= 1'b0; vl_r <= 1'b0;
      fcd_r <= '0; vlc_r <= '0; vact_r <= 1'b0; vbl_r <= 1'b0; hcc_r <= '0;
      hbl_r <= 1'b0; hp_r <= 1'b0; vp_r <= 1'b0; qp_r <= '0;
    end else begin
      pen_r <= pen_nxt; rom_lo_r <= rom_lo_nxt; rom_hi_r <= rom_hi_nxt;
      mode_w_r <= mode_w_nxt; mode_a_r <= mode_a_nxt; lc_r <= lc_nxt;
      irq_r <= irq_nxt; irq_new_r <= irq_new_nxt; recent_r <= recent_nxt;
      due_r <= due_nxt; hl_r <= hl_nxt; vl_r <= vl_nxt; fcd_r <= fcd_nxt;
      vlc_r <= vlc_nxt; vact_r <= vact_nxt; vbl_r <= vbl_nxt;
      hcc_r <= hcc_nxt; hbl_r <= hbl_nxt; hp_r <= hp_nxt; vp_r <= vp_nxt;
      qp_r <= qp_nxt;
    end
  end

  // Status after this item's update.
  assign st = '{irq: irq_nxt, hs: hp_nxt, vs: vp_nxt, rom_lo: rom_lo_nxt,
                rom_hi: rom_hi_nxt, mode: mode_a_nxt};
  assign blanked = hbl_r | vbl_r;

  `include "assert_macros.svh"
  `VGA_ASSERT_IMPL(a_lc_range, 1'b1, lc_r < LINES_PER_IRQ, "line counter out of range")
  `VGA_ASSERT_NEXT(a_irq_new, go && req_type == REQ_QUART, !irq_new_r || irq_r, "new irq lost")
  `VGA_ASSERT_IMPL(a_vp_vact, vp_r, vact_r, "vsync pulse outside vsync")
endmodule

[src/vga_irq_pix.sv]
// ---------------------------------------------------------------------------
// vga_irq_pix
// Ink table, latched bytes and per-half pixel decode.
// ---------------------------------------------------------------------------
module vga_irq_pix (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go_video,
  input  logic        ink_we,
  input  logic [4:0]  ink_addr,
  input  logic [4:0]  ink_data,
  input  logic [1:0]  mode,
  input  logic        blanked,
  input  logic        half,
  input  logic        show_first,
  input  logic        show_second,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  output logic [39:0] codes
);
  import vga_irq_pkg::*;

  logic [4:0] ink_r [17];
  logic [7:0] byte_r [2];
  logic       en_r [2];
  // Second byte of the previous character, kept for the second half word.
  logic [7:0] b1_hold_r;
  logic       en1_hold_r;
  logic [7:0] sel_b;
  logic       sel_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 17; i++) ink_r[i] <= '0;
      byte_r[0] <= '0; byte_r[1] <= '0; en_r[0] <= 1'b0; en_r[1] <= 1'b0;
      b1_hold_r <= '0; en1_hold_r <= 1'b0;
    end else begin
      if (ink_we) ink_r[ink_addr] <= ink_data;
      if (go_video) begin
        b1_hold_r <= byte_r[1]; en1_hold_r <= en_r[1];
        byte_r[0] <= first_byte; byte_r[1] <= second_byte;
        en_r[0] <= show_first;   en_r[1] <= show_second;
      end
    end
  end

  always_comb begin
    sel_b = half ? b1_hold_r : byte_r[0];
    sel_en = half ? en1_hold_r : en_r[0];
    for (int s = 0; s < 8; s++) begin
      if (blanked) codes[5*s +: 5] = INK_BLACK;
      else if (!sel_en) codes[5*s +: 5] = ink_r[PEN_BORDER];
      else codes[5*s +: 5] = ink_r[{1'b0, pen_for_sample(mode, sel_b, 3'(s))}];
    end
  end
endmodule

[src/video_gate_array_with_interrupts.sv]
// ---------------------------------------------------------------------------
// video_gate_array_with_interrupts
// Gate array: bus registers, sync delay, line interrupt, pixel decode.
// ---------------------------------------------------------------------------
// The result word is loaded into the output register as the item is accepted.
// Throughput: one item per cycle while out_stall is low; a video item holds the input
// while its second half word goes out, so no new item is taken in the meantime.
// Reset (rst_n low, synchronous): control and pixel state zero, both ROMs on, output empty.
module video_gate_array_with_interrupts (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_bus_data,
  input  logic        in_hsync_in,
  input  logic        in_vsync_in,
  input  logic        in_show_first,
  input  logic        in_show_second,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_pending,
  output logic        out_sync_h_out,
  output logic        out_sync_v_out,
  output logic        out_low_rom_on,
  output logic        out_high_rom_on,
  output logic [1:0]  out_screen_mode,
  output logic [39:0] out_pixel_codes,
  output logic        out_half_index,
  output logic        out_last_of_run
);
  import vga_irq_pkg::*;

  // Output register; second_r marks the pending second half of a video item.
  logic       ov_r, second_r;
  status_t    st_r, st;
  status_t    st_hold_r;
  logic [39:0] codes_r, codes;
  logic       half_r, last_r;
  logic       load, go, is_video, blanked, blank_hold_r, blank_use;
  logic       ink_we;
  logic [4:0] ink_addr, ink_data;

  // Output slot frees when empty or being taken.
  assign load = !ov_r || !out_stall;
  // Video word is taken with its first half; input held while the second goes out.
  assign is_video = (in_req_type == REQ_VIDEO);
  assign in_stall = !load || second_r;
  assign go = in_valid && load && !second_r;

  vga_irq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(go), .req_type(in_req_type),
    .bus_data(in_bus_data), .hsync_in(in_hsync_in), .vsync_in(in_vsync_in),
    .st(st), .blanked(blanked), .ink_we(ink_we), .ink_addr(ink_addr),
    .ink_data(ink_data)
  );

  // Second half decodes from the blanking seen with the first half.
  assign blank_use = second_r ? blank_hold_r : blanked;

  vga_irq_pix u_pix (
    .clk(clk), .rst_n(rst_n), .go_video(go && is_video),
    .ink_we(ink_we), .ink_addr(ink_addr), .ink_data(ink_data),
    .mode(second_r ? st_hold_r.mode : st.mode), .blanked(blank_use),
    .half(second_r), .show_first(in_show_first), .show_second(in_show_second),
    .first_byte(in_first_byte), .second_byte(in_second_byte), .codes(codes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; second_r <= 1'b0;
    end else if (load) begin
      if (second_r) begin
        ov_r <= 1'b1; second_r <= 1'b0;
      end else begin
        ov_r <= in_valid; second_r <= in_valid && is_video;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_r) begin
        st_r <= st_hold_r; codes_r <= codes; half_r <= 1'b1; last_r <= 1'b1;
      end else begin
        st_r <= st; st_hold_r <= st; blank_hold_r <= blanked;
        codes_r <= is_video ? codes : '0;
        half_r <= 1'b0; last_r <= !is_video;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_irq_pending = st_r.irq;
  assign out_sync_h_out = st_r.hs;
  assign out_sync_v_out = st_r.vs;
  assign out_low_rom_on = st_r.rom_lo;
  assign out_high_rom_on = st_r.rom_hi;
  assign out_screen_mode = st_r.mode;
  assign out_pixel_codes = codes_r;
  assign out_half_index = half_r;
  assign out_last_of_run = last_r;

  `include "assert_macros.svh"
  `VGA_ASSERT_NEXT(a_second_out, second_r && load, ov_r && half_r && last_r, "second half missing")
  `VGA_ASSERT_IMPL(a_half_last, ov_r && half_r, last_r, "half 1 not last")
  `VGA_ASSERT_IMPL(a_no_take, second_r, in_stall, "input taken mid video item")
endmodule
